@@ rtl/multi_button_debounce_encoder_top_defines.svh @@
// assertion macros shared by the debounce encoder checker
// no dependencies
`ifndef MULTI_BUTTON_DEBOUNCE_ENCODER_TOP_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCE_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MBDE_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled in reset
`define MBDE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/mbde_pkg.sv @@
// shared types and constants of the multi-button debounce encoder
// no dependencies
package mbde_pkg;

  localparam int NUM_BUTTONS_DEF = 6;
  localparam int COUNT_WIDTH_DEF = 8;
  localparam int MAX_CODES       = 6;
  localparam int REG_W           = 8;
  localparam int IDX_W           = 3;
  localparam int LEVELS_W        = 6;

  typedef enum logic [IDX_W-1:0] {
    REG_PRESS_TIME   = 3'd0,
    REG_RELEASE_TIME = 3'd1,
    REG_CODE_UP      = 3'd2,
    REG_CODE_DOWN    = 3'd3,
    REG_CODE_LEFT    = 3'd4,
    REG_CODE_RIGHT   = 3'd5,
    REG_CODE_ACT_A   = 3'd6,
    REG_CODE_ACT_B   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FALLING = 2'd1,
    PH_HELD    = 2'd2,
    PH_RISING  = 2'd3
  } phase_t;

  localparam logic [REG_W-1:0] PRESS_TIME_RST   = 8'd15;
  localparam logic [REG_W-1:0] RELEASE_TIME_RST = 8'd15;

  localparam logic [MAX_CODES-1:0][REG_W-1:0] CODE_RST = {
    8'd66, 8'd65, 8'd82, 8'd76, 8'd68, 8'd85
  };

  // per-lane command for one accepted word
  typedef struct packed {
    logic fire;
    logic pin_evt;
    logic low;
  } lane_cmd_t;

endpackage

@@ rtl/mbde_if.sv @@
// valid/ready channel interfaces for the debounce encoder
// depends on mbde_pkg
interface mbde_in_if;
  import mbde_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [LEVELS_W-1:0] levels;

  modport source (output valid, output mode, output levels, input ready);
  modport sink   (input valid, input mode, input levels, output ready);
endinterface

interface mbde_out_if;
  import mbde_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] button_index;
  logic [REG_W-1:0] code_byte;
  logic             last_of_tick;

  modport source (output valid, output button_index, output code_byte,
                  output last_of_tick, input ready);
  modport sink   (input valid, input button_index, input code_byte,
                  input last_of_tick, output ready);
endinterface

@@ rtl/multi_button_debounce_encoder_top.sv @@
// Debounce encoder for up to six active-low buttons. Every input word updates all
// buttons at once in parallel lanes; pin-change words and ticks that confirm no press
// leave the input ready on the next cycle, so one word per cycle is sustained. A tick
// that confirms k presses yields k output words in button order from the merge
// register, one per cycle while out_ready is high; the input is held off until the
// cycle in which the last of them is taken. The user must write registers through
// cfg_we/cfg_index/cfg_data only while the block is idle, which it does not enforce.
// depends on mbde_pkg, mbde_if, mbde_lane, mbde_merge
module multi_button_debounce_encoder_top #(
  parameter int NUM_BUTTONS = mbde_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = mbde_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mbde_in_if.sink                    in_chan,
  mbde_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [mbde_pkg::IDX_W-1:0] cfg_index,
  input  logic [mbde_pkg::REG_W-1:0] cfg_data
);
  import mbde_pkg::*;

  localparam int LANES = (NUM_BUTTONS < MAX_CODES) ? NUM_BUTTONS : MAX_CODES;

  logic [REG_W-1:0]                 press_time_r, release_time_r;
  logic [MAX_CODES-1:0][REG_W-1:0]  code_r;
  logic                             in_fire, accept_ok;
  logic [LANES-1:0]                 press;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_time_r   <= PRESS_TIME_RST;
      release_time_r <= RELEASE_TIME_RST;
      code_r         <= CODE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRESS_TIME:   press_time_r   <= cfg_data;
        REG_RELEASE_TIME: release_time_r <= cfg_data;
        REG_CODE_UP:      code_r[0]      <= cfg_data;
        REG_CODE_DOWN:    code_r[1]      <= cfg_data;
        REG_CODE_LEFT:    code_r[2]      <= cfg_data;
        REG_CODE_RIGHT:   code_r[3]      <= cfg_data;
        REG_CODE_ACT_A:   code_r[4]      <= cfg_data;
        REG_CODE_ACT_B:   code_r[5]      <= cfg_data;
        default:          press_time_r   <= press_time_r;
      endcase
    end
  end

  assign in_fire       = in_chan.valid && accept_ok;
  assign in_chan.ready = accept_ok;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lane_cmd_t cmd;
    assign cmd.fire    = in_fire;
    assign cmd.pin_evt = in_chan.mode;
    assign cmd.low     = !in_chan.levels[g];

    mbde_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .press_time   (press_time_r),
      .release_time (release_time_r),
      .press        (press[g])
    );
  end

  mbde_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && !in_chan.mode),
    .press     (press),
    .codes     (code_r),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_index (out_chan.button_index),
    .out_code  (out_chan.code_byte),
    .out_last  (out_chan.last_of_tick),
    .accept_ok (accept_ok)
  );

endmodule

@@ rtl/mbde_lane.sv @@
// one button lane: four-phase debounce machine and saturating tick counter
// depends on mbde_pkg
module mbde_lane #(
  parameter int COUNT_WIDTH = mbde_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mbde_pkg::lane_cmd_t        cmd,
  input  logic [mbde_pkg::REG_W-1:0] press_time,
  input  logic [mbde_pkg::REG_W-1:0] release_time,
  output logic                       press
);
  import mbde_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                   press_hit, release_hit;

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_WIDTH'(1);

  // a saturated counter always meets a threshold beyond its range
  assign press_hit   = (CMP_W'(cnt_inc) >= CMP_W'(press_time)) || (cnt_inc == CNT_MAX);
  assign release_hit = (CMP_W'(cnt_inc) >= CMP_W'(release_time)) || (cnt_inc == CNT_MAX);

  always_comb begin
    phase_nxt = phase_r;
    if (cmd.fire) begin
      if (cmd.pin_evt) begin
        if (phase_r == PH_IDLE && cmd.low) begin
          phase_nxt = PH_FALLING;
        end
      end else begin
        case (phase_r)
          PH_FALLING: begin
            if (press_hit) begin
              phase_nxt = cmd.low ? PH_HELD : PH_IDLE;
            end
          end
          PH_HELD: begin
            if (!cmd.low) begin
              phase_nxt = PH_RISING;
            end
          end
          PH_RISING: begin
            if (release_hit) begin
              phase_nxt = cmd.low ? PH_HELD : PH_IDLE;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    press   = 1'b0;
    if (cmd.fire) begin
      if (cmd.pin_evt) begin
        if (phase_r == PH_IDLE && cmd.low) begin
          cnt_nxt = '0;
        end
      end else begin
        if (phase_r == PH_HELD && !cmd.low) begin
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
        press = (phase_r == PH_FALLING) && press_hit && cmd.low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/mbde_merge.sv @@
// merge stage: holds the confirmed presses of one tick and sends them in button order
// depends on mbde_pkg
module mbde_merge #(
  parameter int LANES = mbde_pkg::MAX_CODES
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           load,
  input  logic [LANES-1:0]                               press,
  input  logic [mbde_pkg::MAX_CODES-1:0][mbde_pkg::REG_W-1:0] codes,
  input  logic                                           out_ready,
  output logic                                           out_valid,
  output logic [mbde_pkg::IDX_W-1:0]                     out_index,
  output logic [mbde_pkg::REG_W-1:0]                     out_code,
  output logic                                           out_last,
  output logic                                           accept_ok
);
  import mbde_pkg::*;

  logic [LANES-1:0] pend_r, pend_nxt;
  logic [LANES-1:0] first_oh;
  logic [IDX_W-1:0] idx;

  assign first_oh = pend_r & (~pend_r + LANES'(1));

  always_comb begin
    idx = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign out_valid = |pend_r;
  assign out_index = idx;
  assign out_code  = codes[idx];
  assign out_last  = ((pend_r & ~first_oh) == '0);
  assign accept_ok = !out_valid || (out_ready && out_last);

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = press;
    end else if (out_valid && out_ready) begin
      pend_nxt = pend_r & ~first_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

endmodule

@@ rtl/mbde_checker.sv @@
// port-level checks of the debounce encoder, bound to the top level
// depends on mbde_pkg and the assertion macro header
`include "multi_button_debounce_encoder_top_defines.svh"

module mbde_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_mode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mbde_pkg::IDX_W-1:0] out_button_index,
  input logic [mbde_pkg::REG_W-1:0] out_code_byte,
  input logic                       out_last_of_tick
);
  import mbde_pkg::*;

  `MBDE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output word dropped while stalled")
  `MBDE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_button_index) && $stable(out_code_byte) && $stable(out_last_of_tick), "stalled output word changed")
  `MBDE_ASSERT_NOW(a_index_range, clk, rst_n, out_valid, out_button_index < IDX_W'(MAX_CODES), "button index out of range")
  `MBDE_ASSERT_NEXT(a_pin_silent, clk, rst_n, in_valid && in_ready && in_mode, !out_valid, "pin change produced an output word")
  `MBDE_ASSERT_NOW(a_hold_input, clk, rst_n, out_valid && !(out_ready && out_last_of_tick), !in_ready, "input taken while tick words pending")

endmodule

bind multi_button_debounce_encoder_top mbde_checker u_mbde_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_mode          (in_chan.mode),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_button_index (out_chan.button_index),
  .out_code_byte    (out_chan.code_byte),
  .out_last_of_tick (out_chan.last_of_tick)
);
